// ----- hw/rtl/smns_pkg.sv -----
// Package for the sensor-to-MIDI note sequencer.
// Holds the item types, register indexes, reset values and message codes.
// Used by sensor_to_midi_note_sequencer and tb_top; depends on nothing.
package smns_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ON_THRESHOLD       = 3'd0;
  localparam logic [2:0] REG_OFF_THRESHOLD      = 3'd1;
  localparam logic [2:0] REG_HOLD_TICKS         = 3'd2;
  localparam logic [2:0] REG_NOTE_VELOCITY      = 3'd3;
  localparam logic [2:0] REG_BEND_WEIGHT        = 3'd4;
  localparam logic [2:0] REG_BEND_PER_TONE      = 3'd5;
  localparam logic [2:0] REG_BEND_PER_FINE_STEP = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // Register reset values.
  localparam logic [6:0] ON_THRESHOLD_RST       = 7'd32;
  localparam logic [6:0] OFF_THRESHOLD_RST      = 7'd16;
  localparam logic [7:0] HOLD_TICKS_RST         = 8'd10;
  localparam logic [6:0] NOTE_VELOCITY_RST      = 7'd96;
  localparam logic [4:0] BEND_WEIGHT_RST        = 5'd8;
  localparam logic [9:0] BEND_PER_TONE_RST      = 10'd341;
  localparam logic [7:0] BEND_PER_FINE_STEP_RST = 8'd43;

  // Input operations.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Message codes.
  localparam logic [3:0] CIN_NOTE_ON     = 4'd9;
  localparam logic [3:0] CIN_CTRL        = 4'd11;
  localparam logic [3:0] CIN_BEND        = 4'd14;
  localparam logic [7:0] ST_NOTE_ON      = 8'h90;
  localparam logic [7:0] ST_CTRL         = 8'hB0;
  localparam logic [7:0] ST_BEND         = 8'hE0;
  localparam logic [6:0] CTRL_EXPRESSION = 7'h0B;

  // Bend arithmetic.
  localparam logic signed [25:0] BEND_CENTER = 26'sd8192;
  localparam logic [13:0]        BEND_MAX    = 14'h3FFF;
  localparam logic [4:0]         WEIGHT_FULL = 5'd16;

  // Start sequence phases.
  localparam logic [1:0] PHASE_CTRL = 2'd0;
  localparam logic [1:0] PHASE_BEND = 2'd1;
  localparam logic [1:0] PHASE_NOTE = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [6:0]        tone;
    logic signed [7:0] fine_pitch;
    logic [6:0]        expression;
    logic              tx_busy;
  } smns_in_t;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
  } smns_out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FINE,
    ST_TONE,
    ST_CLAMP,
    ST_WNEW,
    ST_WOLD,
    ST_DONE
  } smns_state_t;

endpackage

// ----- hw/rtl/sensor_to_midi_note_sequencer.sv -----
// Top level of the sensor-to-MIDI note sequencer.
// Depends on smns_pkg for item types, register indexes and message codes.
//
// Usage: the input channel (in_valid, in_stall, in_item) carries one item per
// tick or sensor poll. The output channel (out_valid, out_stall, out_item)
// carries zero or one MIDI message per item. The user writes registers through
// cfg_we, cfg_index and cfg_data only while the block is idle; the block itself
// does not enforce this. A tick item is handled in the idle state as it is
// accepted, and so is a poll while the hold counter is nonzero. A poll that
// finds the counter at zero runs through one shared signed multiplier and
// accumulator. While a note sounds the steps are fine bend, tone bend, clamp,
// the two smoothing products and a decision step, after which any message is
// registered and the block returns to idle for the next item. With no note
// sounding only fine bend, clamp and decision run. The block takes one item
// at a time and raises in_stall while a poll is in progress.
// A result sits in an output register; the next item is accepted while it
// waits, and the decision step holds only if a new message would overwrite
// a message still stalled at the output.
// Reset (rst, synchronous) clears the sequence state and restores the
// register defaults; no clearing pass is needed.
module sensor_to_midi_note_sequencer
  import smns_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  smns_in_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output smns_out_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [6:0] on_threshold;
  logic [6:0] off_threshold;
  logic [7:0] hold_ticks;
  logic [6:0] note_velocity;
  logic [4:0] bend_weight;
  logic [9:0] bend_per_tone;
  logic [7:0] bend_per_fine_step;

  // Sequence state.
  logic [7:0]  tick_count, tick_count_next;
  logic        note_active, note_active_next;
  logic [1:0]  start_phase, start_phase_next;
  logic [6:0]  held_note, held_note_next;
  logic [13:0] held_bend, held_bend_next;
  logic [6:0]  held_expression, held_expression_next;

  smns_state_t state, state_next;
  smns_in_t    item;
  logic signed [25:0] acc;
  logic [13:0] target;

  logic signed [14:0] mul_a;
  logic signed [10:0] mul_b;
  logic signed [25:0] prod;
  logic [4:0]  weight;
  logic [4:0]  weight_inv;
  logic signed [7:0] tone_diff;
  logic [13:0] smooth;
  logic        in_take;
  logic        res_valid;
  smns_out_t   res_item;
  logic        done_go;

  assign in_take    = in_valid && !in_stall;
  assign weight     = (bend_weight > WEIGHT_FULL) ? WEIGHT_FULL : bend_weight;
  assign weight_inv = WEIGHT_FULL - weight;
  assign tone_diff  = $signed({1'b0, item.tone}) - $signed({1'b0, held_note});
  assign prod       = mul_a * mul_b;
  assign smooth     = acc[17:4];
  assign done_go    = (state == ST_DONE) && (!res_valid || !out_valid || !out_stall);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_threshold       <= ON_THRESHOLD_RST;
      off_threshold      <= OFF_THRESHOLD_RST;
      hold_ticks         <= HOLD_TICKS_RST;
      note_velocity      <= NOTE_VELOCITY_RST;
      bend_weight        <= BEND_WEIGHT_RST;
      bend_per_tone      <= BEND_PER_TONE_RST;
      bend_per_fine_step <= BEND_PER_FINE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_THRESHOLD:       on_threshold       <= cfg_data[6:0];
        REG_OFF_THRESHOLD:      off_threshold      <= cfg_data[6:0];
        REG_HOLD_TICKS:         hold_ticks         <= cfg_data[7:0];
        REG_NOTE_VELOCITY:      note_velocity      <= cfg_data[6:0];
        REG_BEND_WEIGHT:        bend_weight        <= cfg_data[4:0];
        REG_BEND_PER_TONE:      bend_per_tone      <= cfg_data[9:0];
        REG_BEND_PER_FINE_STEP: bend_per_fine_step <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && in_item.operation == OP_POLL && tick_count == 8'd0) begin
          state_next = ST_FINE;
        end
      end
      ST_FINE:  state_next = note_active ? ST_TONE : ST_CLAMP;
      ST_TONE:  state_next = ST_CLAMP;
      ST_CLAMP: state_next = note_active ? ST_WNEW : ST_DONE;
      ST_WNEW:  state_next = ST_WOLD;
      ST_WOLD:  state_next = ST_DONE;
      ST_DONE: begin
        if (done_go) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands and input stall by state.
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      ST_FINE: begin
        mul_a = 15'(item.fine_pitch);
        mul_b = $signed({3'b000, bend_per_fine_step});
      end
      ST_TONE: begin
        mul_a = 15'(tone_diff);
        mul_b = $signed({1'b0, bend_per_tone});
      end
      ST_WNEW: begin
        mul_a = $signed({1'b0, target});
        mul_b = $signed({6'b000000, weight});
      end
      ST_WOLD: begin
        mul_a = $signed({1'b0, held_bend});
        mul_b = $signed({6'b000000, weight_inv});
      end
      default: ;
    endcase
  end

  // Decision step: chosen message and state updates; in idle, the tick decrement.
  always_comb begin
    res_valid            = 1'b0;
    res_item             = '0;
    tick_count_next      = tick_count;
    note_active_next     = note_active;
    start_phase_next     = start_phase;
    held_note_next       = held_note;
    held_bend_next       = held_bend;
    held_expression_next = held_expression;
    if (state == ST_IDLE) begin
      if (in_take && in_item.operation == OP_TICK && tick_count != 8'd0) begin
        tick_count_next = tick_count - 8'd1;
      end
    end else if (state == ST_DONE) begin
      if (!note_active) begin
        if (item.expression > on_threshold) begin
          tick_count_next = hold_ticks;
          if (start_phase == PHASE_CTRL) begin
            held_note_next       = item.tone;
            held_bend_next       = target;
            held_expression_next = item.expression;
            start_phase_next     = PHASE_BEND;
            res_valid            = !item.tx_busy;
            res_item = '{CIN_CTRL, ST_CTRL, CTRL_EXPRESSION, item.expression};
          end else if (start_phase == PHASE_BEND) begin
            start_phase_next = PHASE_NOTE;
            res_valid        = !item.tx_busy;
            res_item = '{CIN_BEND, ST_BEND, held_bend[6:0], held_bend[13:7]};
          end else begin
            note_active_next = 1'b1;
            start_phase_next = PHASE_CTRL;
            res_valid        = !item.tx_busy;
            res_item = '{CIN_NOTE_ON, ST_NOTE_ON, held_note, note_velocity};
          end
        end
      end else if (item.expression < off_threshold) begin
        // The note ends; the hold counter is not reloaded.
        note_active_next = 1'b0;
        res_valid        = !item.tx_busy;
        res_item         = '{CIN_NOTE_ON, ST_NOTE_ON, held_note, 7'd0};
      end else begin
        tick_count_next      = hold_ticks;
        held_bend_next       = smooth;
        held_expression_next = item.expression;
        res_valid            = !item.tx_busy;
        if (item.expression != held_expression) begin
          res_item = '{CIN_CTRL, ST_CTRL, CTRL_EXPRESSION, item.expression};
        end else begin
          res_item = '{CIN_BEND, ST_BEND, smooth[6:0], smooth[13:7]};
        end
      end
    end
  end

  // Control state and held sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tick_count      <= '0;
      note_active     <= 1'b0;
      start_phase     <= PHASE_CTRL;
      held_note       <= '0;
      held_bend       <= '0;
      held_expression <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE || done_go) begin
        tick_count      <= tick_count_next;
        note_active     <= note_active_next;
        start_phase     <= start_phase_next;
        held_note       <= held_note_next;
        held_bend       <= held_bend_next;
        held_expression <= held_expression_next;
      end
    end
  end

  // Latched item, accumulator and clamped bend target.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_item;
    end
    case (state)
      ST_FINE:  acc <= BEND_CENTER + prod;
      ST_TONE:  acc <= acc + prod;
      ST_CLAMP: begin
        acc <= '0;
        if (acc[25]) begin
          target <= '0;
        end else if (|acc[24:14]) begin
          target <= BEND_MAX;
        end else begin
          target <= acc[13:0];
        end
      end
      ST_WNEW:  acc <= prod;
      ST_WOLD:  acc <= acc + prod;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (done_go && res_valid) begin
      out_item <= res_item;
    end
  end

`ifndef SYNTHESIS
  a_phase_only_off: assert property (@(posedge clk) disable iff (rst)
    start_phase != PHASE_CTRL |-> !note_active)
    else $error("start phase advanced while a note sounds");

  a_note_start: assert property (@(posedge clk) disable iff (rst)
    $rose(note_active) |-> $past(start_phase) != PHASE_CTRL && $past(start_phase) != PHASE_BEND)
    else $error("note started before the bend phase");

  a_tick_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && tick_count != $past(tick_count)
      |-> tick_count == $past(tick_count) - 8'd1 || tick_count == $past(hold_ticks))
    else $error("hold counter moved other than by decrement or reload");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && res_valid && out_valid && out_stall |=> state == ST_DONE)
    else $error("decision step left while a stalled message waits");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the sensor-to-MIDI note sequencer.
// Depends on smns_pkg and sensor_to_midi_note_sequencer; it predicts every MIDI
// message from its own copy of the sequencer state and checks the output in order.
module tb_top;
  import smns_pkg::*;

  // Receiver stall patterns.
  localparam logic [1:0] STALL_NONE  = 2'd0;
  localparam logic [1:0] STALL_LIGHT = 2'd1;
  localparam logic [1:0] STALL_HEAVY = 2'd2;
  localparam logic [1:0] STALL_LONG  = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  smns_in_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  smns_out_t              out_item;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  sensor_to_midi_note_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be driven and messages waiting to come out.
  smns_in_t  sensor_feed[$];
  smns_out_t midi_expected[$];
  smns_out_t midi_want;

  int items_taken    = 0;
  int msgs_checked   = 0;
  int mismatch_count = 0;
  int settings_used  = 0;

  // Predicted register values.
  logic [6:0] c_on     = ON_THRESHOLD_RST;
  logic [6:0] c_off    = OFF_THRESHOLD_RST;
  logic [7:0] c_hold   = HOLD_TICKS_RST;
  logic [6:0] c_vel    = NOTE_VELOCITY_RST;
  logic [4:0] c_weight = BEND_WEIGHT_RST;
  logic [9:0] c_tone   = BEND_PER_TONE_RST;
  logic [7:0] c_fine   = BEND_PER_FINE_STEP_RST;

  // Predicted sequencer state.
  logic [7:0]  m_ticks    = '0;
  logic        m_sounding = 1'b0;
  logic [1:0]  m_phase    = PHASE_CTRL;
  logic [6:0]  m_note     = '0;
  logic [13:0] m_bend     = '0;
  logic [6:0]  m_expr     = '0;

  // Random walk of the sensed values.
  logic [6:0] gen_expr = '0;
  logic [6:0] gen_tone = 7'd60;

  function automatic logic [13:0] clamp_bend(int v);
    if (v < 0) return '0;
    if (v > int'(BEND_MAX)) return BEND_MAX;
    return v[13:0];
  endfunction

  function automatic logic [6:0] clip7(int v);
    if (v < 0) return 7'd0;
    if (v > 127) return 7'd127;
    return v[6:0];
  endfunction

  // Advance the predicted sequencer by one accepted item and queue any message.
  function automatic void advance_sequencer(smns_in_t it);
    int        fine_bend;
    int        diff;
    int        target;
    int        w;
    int        smooth;
    bit        has_msg;
    smns_out_t msg;
    has_msg = 1'b0;
    msg = '0;
    fine_bend = int'($signed(it.fine_pitch)) * int'(c_fine);
    if (it.operation == OP_TICK) begin
      if (m_ticks != 0) m_ticks = m_ticks - 8'd1;
    end else if (m_ticks != 0) begin
      // The hold counter is running: the poll does nothing.
    end else if (!m_sounding) begin
      if (it.expression > c_on) begin
        has_msg = 1'b1;
        m_ticks = c_hold;
        if (m_phase == PHASE_CTRL) begin
          m_note  = it.tone;
          m_bend  = clamp_bend(int'(BEND_CENTER) + fine_bend);
          m_expr  = it.expression;
          m_phase = PHASE_BEND;
          msg = '{CIN_CTRL, ST_CTRL, CTRL_EXPRESSION, m_expr};
        end else if (m_phase == PHASE_BEND) begin
          m_phase = PHASE_NOTE;
          msg = '{CIN_BEND, ST_BEND, m_bend[6:0], m_bend[13:7]};
        end else begin
          m_sounding = 1'b1;
          m_phase = PHASE_CTRL;
          msg = '{CIN_NOTE_ON, ST_NOTE_ON, m_note, c_vel};
        end
      end
    end else if (it.expression < c_off) begin
      // Note end: velocity zero and no counter reload.
      m_sounding = 1'b0;
      has_msg = 1'b1;
      msg = '{CIN_NOTE_ON, ST_NOTE_ON, m_note, 7'd0};
    end else begin
      diff   = int'(it.tone) - int'(m_note);
      target = int'(clamp_bend(int'(BEND_CENTER) + int'(c_tone) * diff + fine_bend));
      w      = (c_weight > WEIGHT_FULL) ? 16 : int'(c_weight);
      smooth = (target * w + int'(m_bend) * (16 - w)) / 16;
      has_msg = 1'b1;
      m_ticks = c_hold;
      m_bend  = smooth[13:0];
      // A changed expression wins; the smoothed bend is kept but not sent.
      if (it.expression != m_expr)
        msg = '{CIN_CTRL, ST_CTRL, CTRL_EXPRESSION, it.expression};
      else
        msg = '{CIN_BEND, ST_BEND, m_bend[6:0], m_bend[13:7]};
      m_expr = it.expression;
    end
    if (has_msg && !it.tx_busy) midi_expected.push_back(msg);
  endfunction

  function automatic smns_in_t make_item(logic op, int tone, int fine, int expr, int busy);
    smns_in_t it;
    it.operation  = op;
    it.tone       = tone[6:0];
    it.fine_pitch = fine[7:0];
    it.expression = expr[6:0];
    it.tx_busy    = (busy != 0);
    return it;
  endfunction

  // A tick carries random sensor fields that the block must ignore.
  function automatic smns_in_t random_tick();
    return make_item(OP_TICK, $urandom_range(0, 127), $urandom_range(0, 255),
                     $urandom_range(0, 127), $urandom_range(0, 1));
  endfunction

  // A poll whose expression and tone mostly drift, with jumps and threshold hits.
  function automatic smns_in_t random_poll();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'(gen_expr);
      4, 5, 6: v = int'(gen_expr) + int'($urandom_range(0, 8)) - 4;
      7: v = $urandom_range(0, 127);
      8: begin
        case ($urandom_range(0, 3))
          0: v = int'(c_off) - 1;
          1: v = int'(c_off);
          2: v = int'(c_on);
          default: v = int'(c_on) + 1;
        endcase
      end
      default: v = ($urandom_range(0, 1) != 0) ? 127 : 0;
    endcase
    gen_expr = clip7(v);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'(gen_tone);
      6, 7, 8: v = int'(gen_tone) + int'($urandom_range(0, 6)) - 3;
      default: v = $urandom_range(0, 127);
    endcase
    gen_tone = clip7(v);
    return make_item(OP_POLL, gen_tone, $urandom_range(0, 255), gen_expr,
                     int'($urandom_range(0, 7) == 0));
  endfunction

  // Mostly ticks that just run the hold counter out before each poll.
  task automatic queue_random(int count);
    int made;
    int ticks;
    int r;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 9);
      if (r < 7) ticks = int'(c_hold);
      else if (r < 9) ticks = $urandom_range(0, int'(c_hold) + 2);
      else ticks = 0;
      repeat (ticks) begin
        sensor_feed.push_back(random_tick());
        made++;
      end
      sensor_feed.push_back(random_poll());
      made++;
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_ON_THRESHOLD:       c_on     = val[6:0];
      REG_OFF_THRESHOLD:      c_off    = val[6:0];
      REG_HOLD_TICKS:         c_hold   = val[7:0];
      REG_NOTE_VELOCITY:      c_vel    = val[6:0];
      REG_BEND_WEIGHT:        c_weight = val[4:0];
      REG_BEND_PER_TONE:      c_tone   = val[9:0];
      REG_BEND_PER_FINE_STEP: c_fine   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int on_t, int off_t, int hold, int vel, int weight,
                            int per_tone, int per_fine);
    write_reg(REG_ON_THRESHOLD, CFG_DATA_W'(on_t));
    write_reg(REG_OFF_THRESHOLD, CFG_DATA_W'(off_t));
    write_reg(REG_HOLD_TICKS, CFG_DATA_W'(hold));
    write_reg(REG_NOTE_VELOCITY, CFG_DATA_W'(vel));
    write_reg(REG_BEND_WEIGHT, CFG_DATA_W'(weight));
    write_reg(REG_BEND_PER_TONE, CFG_DATA_W'(per_tone));
    write_reg(REG_BEND_PER_FINE_STEP, CFG_DATA_W'(per_fine));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Wait until every item is in and every message is out, then let a
  // poll that makes no message finish its pass.
  task automatic wait_idle();
    do @(negedge clk);
    while (sensor_feed.size() != 0 || in_valid || midi_expected.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // Sender: bursts of items with random gaps between them.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      in_item    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_sequencer(in_item);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sensor_feed.size() != 0) begin
          in_valid <= 1'b1;
          in_item  <= sensor_feed.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                      : $urandom_range(1, 12);
            gap_left   <= $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that switches between quiet, light, heavy and long stalls.
  logic [1:0] stall_mode = STALL_NONE;
  int         mode_left  = 0;
  int         stall_len  = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left  <= 0;
      stall_len  <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        STALL_LONG: begin
          if (stall_len != 0) begin
            out_stall <= 1'b1;
            stall_len <= stall_len - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            stall_len <= $urandom_range(1, 15);
          end else begin
            out_stall <= 1'b0;
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Checker: every accepted message against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (midi_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected message cin %0d status %h data %h %h",
                   out_item.code_index, out_item.status_byte,
                   out_item.data_first, out_item.data_second);
      end else begin
        midi_want = midi_expected.pop_front();
        msgs_checked++;
        if (out_item.code_index != midi_want.code_index ||
            out_item.status_byte != midi_want.status_byte ||
            out_item.data_first != midi_want.data_first ||
            out_item.data_second != midi_want.data_second) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: msg %0d want cin %0d st %h data %h %h, got cin %0d st %h data %h %h",
                     msgs_checked, midi_want.code_index, midi_want.status_byte,
                     midi_want.data_first, midi_want.data_second,
                     out_item.code_index, out_item.status_byte,
                     out_item.data_first, out_item.data_second);
        end
      end
    end
  end

  // Stimulus: a directed start, then random phases over several register settings.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: thresholds, a full start sequence, dropped messages, note ends.
    set_config(32, 16, 1, 96, 8, 341, 43);
    @(negedge clk);
    sensor_feed.push_back(make_item(OP_POLL, 0, 0, 0, 0));        // below on threshold
    sensor_feed.push_back(make_item(OP_POLL, 0, 0, 32, 0));       // equal to on threshold
    sensor_feed.push_back(make_item(OP_POLL, 127, -128, 33, 0));  // control change
    sensor_feed.push_back(make_item(OP_POLL, 5, 3, 90, 0));       // counter running
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_TICK, 127, 127, 127, 1));  // counter already zero
    sensor_feed.push_back(make_item(OP_POLL, 0, 0, 127, 1));      // bend dropped
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 0, 127, 127, 0));    // note-on
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 0, 127, 127, 0));    // expression moved
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 0, 127, 127, 0));    // bend clamped low
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 127, 127, 127, 0));  // bend back up
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 127, 0, 16, 0));     // equal to off threshold
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 127, 0, 15, 1));     // note end dropped
    sensor_feed.push_back(make_item(OP_POLL, 64, 0, 0, 0));       // note off, quiet
    sensor_feed.push_back(make_item(OP_POLL, 64, 0, 127, 0));     // restart without ticks
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 64, 0, 127, 0));
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 64, 0, 127, 0));
    sensor_feed.push_back(make_item(OP_TICK, 0, 0, 0, 0));
    sensor_feed.push_back(make_item(OP_POLL, 64, -1, 15, 0));     // note end sent
    wait_idle();

    // Random phases; extremes of every register among them, but for a note velocity of zero.
    set_config(32, 16, 0, 127, 16, 1023, 255);
    @(negedge clk);
    queue_random(400);
    wait_idle();

    set_config(0, 127, 1, 1, 1, 0, 0);
    @(negedge clk);
    queue_random(250);
    wait_idle();

    set_config(127, 0, 3, 127, 0, 1023, 255);
    @(negedge clk);
    queue_random(150);
    wait_idle();

    set_config(20, 20, 2, 64, 31, 341, 43);
    @(negedge clk);
    queue_random(400);
    wait_idle();

    set_config(40, 10, 255, 100, 4, 500, 100);
    @(negedge clk);
    queue_random(300);
    wait_idle();

    repeat (3) begin
      set_config($urandom_range(0, 100), $urandom_range(0, 60), $urandom_range(0, 4),
                 $urandom_range(1, 127), $urandom_range(0, 31), $urandom_range(0, 1023),
                 $urandom_range(0, 255));
      @(negedge clk);
      queue_random(150);
      wait_idle();
    end

    $display("Summary: %0d sensor items over %0d register settings, %0d MIDI messages checked.",
             items_taken, settings_used, msgs_checked);
    $display("Summary: %0d mismatching or unexpected messages.", mismatch_count);
    if (mismatch_count == 0 && midi_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("Timeout with %0d messages still expected.", midi_expected.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sensor_to_midi_note_sequencer.f -----
hw/rtl/smns_pkg.sv
hw/rtl/sensor_to_midi_note_sequencer.sv
tb/tb_top.sv
